@@ rtl/rto_pkg.sv @@
// Package for the rectangle/triangle overlap block: coordinate widths, the point
// and query types, and the exact determinant, orientation and containment helpers.
// It depends on nothing else.
package rto_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int PT_W       = COORD_BITS + 1;
  localparam int DIFF_W     = PT_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DET_W      = PROD_W + 1;

  typedef logic signed [PT_W-1:0]   coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rect_x;
    logic signed [COORD_BITS-1:0] rect_y;
    logic [SIZE_BITS-1:0]         rect_w;
    logic [SIZE_BITS-1:0]         rect_h;
    logic signed [COORD_BITS-1:0] tri_ax;
    logic signed [COORD_BITS-1:0] tri_ay;
    logic signed [COORD_BITS-1:0] tri_bx;
    logic signed [COORD_BITS-1:0] tri_by;
    logic signed [COORD_BITS-1:0] tri_cx;
    logic signed [COORD_BITS-1:0] tri_cy;
  } query_t;

  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_CW  = 2'd1,
    ORI_CCW = 2'd2
  } orient_e;

  function automatic diff_t sub(coord_t a, coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // Exact value of a*b - c*d.
  function automatic det_t det(diff_t a, diff_t b, diff_t c, diff_t d);
    logic signed [PROD_W-1:0] pab;
    logic signed [PROD_W-1:0] pcd;
    pab = a * b;
    pcd = c * d;
    return DET_W'(pab) - DET_W'(pcd);
  endfunction

  function automatic logic positive(det_t v);
    return !v[DET_W-1] && (v != '0);
  endfunction

  function automatic orient_e orient(pt_t p, pt_t q, pt_t r);
    det_t v;
    v = det(sub(q.y, p.y), sub(r.x, q.x), sub(q.x, p.x), sub(r.y, q.y));
    if (v == '0) begin
      return ORI_COL;
    end
    return v[DET_W-1] ? ORI_CCW : ORI_CW;
  endfunction

  // True when q lies in the bounding box of p and r.
  function automatic logic on_seg(pt_t p, pt_t q, pt_t r);
    return (q.x <= p.x || q.x <= r.x) && (q.x >= p.x || q.x >= r.x) &&
           (q.y <= p.y || q.y <= r.y) && (q.y >= p.y || q.y >= r.y);
  endfunction

  function automatic logic in_tri(pt_t p, pt_t a, pt_t b, pt_t c);
    logic s_ab;
    logic s_ac;
    logic s_bc;
    s_ab = positive(det(sub(b.x, a.x), sub(p.y, a.y), sub(b.y, a.y), sub(p.x, a.x)));
    s_ac = positive(det(sub(c.x, a.x), sub(p.y, a.y), sub(c.y, a.y), sub(p.x, a.x)));
    s_bc = positive(det(sub(c.x, b.x), sub(p.y, b.y), sub(c.y, b.y), sub(p.x, b.x)));
    return (s_ac != s_ab) && (s_bc == s_ab);
  endfunction

endpackage

@@ rtl/rto_seg_test.sv @@
// Segment intersection test between one rectangle edge and one triangle edge,
// using orientations with the collinear on-segment cases. Depends on rto_pkg.
module rto_seg_test import rto_pkg::*; (
  input  pt_t  p1_i,
  input  pt_t  q1_i,
  input  pt_t  p2_i,
  input  pt_t  q2_i,
  output logic hit_o
);

  orient_e o1, o2, o3, o4;

  always_comb begin
    o1 = orient(p1_i, q1_i, p2_i);
    o2 = orient(p1_i, q1_i, q2_i);
    o3 = orient(p2_i, q2_i, p1_i);
    o4 = orient(p2_i, q2_i, q1_i);
    hit_o = ((o1 != o2) && (o3 != o4)) ||
            ((o1 == ORI_COL) && on_seg(p1_i, p2_i, q1_i)) ||
            ((o2 == ORI_COL) && on_seg(p1_i, q2_i, q1_i)) ||
            ((o3 == ORI_COL) && on_seg(p2_i, p1_i, q2_i)) ||
            ((o4 == ORI_COL) && on_seg(p2_i, q1_i, q2_i));
  end

endmodule

@@ rtl/rto_eval.sv @@
// Combinational overlap evaluation for one registered query: vertex-in-rectangle,
// corner-in-triangle and all edge pair tests. Depends on rto_pkg, rto_seg_test.
module rto_eval import rto_pkg::*; (
  input  query_t query_i,
  output logic   overlap_o
);

  coord_t l, t, r, b;
  pt_t    tv [3];
  pt_t    corner [4];
  pt_t    e0 [4];
  pt_t    e1 [4];
  logic [2:0]  vtx_in;
  logic [3:0]  cor_in;
  logic [11:0] seg_hit;

  always_comb begin
    l = PT_W'(query_i.rect_x);
    t = PT_W'(query_i.rect_y);
    r = l + coord_t'({1'b0, query_i.rect_w});
    b = t + coord_t'({1'b0, query_i.rect_h});
    tv[0] = '{x: PT_W'(query_i.tri_ax), y: PT_W'(query_i.tri_ay)};
    tv[1] = '{x: PT_W'(query_i.tri_bx), y: PT_W'(query_i.tri_by)};
    tv[2] = '{x: PT_W'(query_i.tri_cx), y: PT_W'(query_i.tri_cy)};
    corner[0] = '{x: l, y: t};
    corner[1] = '{x: r, y: t};
    corner[2] = '{x: l, y: b};
    corner[3] = '{x: r, y: b};
    e0[0] = corner[0];
    e1[0] = corner[1];
    e0[1] = corner[0];
    e1[1] = corner[2];
    e0[2] = corner[3];
    e1[2] = corner[2];
    e0[3] = corner[3];
    e1[3] = corner[1];
    for (int i = 0; i < 3; i++) begin
      vtx_in[i] = (tv[i].x >= l) && (tv[i].x <= r) && (tv[i].y >= t) && (tv[i].y <= b);
    end
    for (int i = 0; i < 4; i++) begin
      cor_in[i] = in_tri(corner[i], tv[0], tv[1], tv[2]);
    end
  end

  for (genvar gi = 0; gi < 4; gi++) begin : g_rect_edge
    for (genvar gj = 0; gj < 3; gj++) begin : g_tri_edge
      rto_seg_test u_seg (
        .p1_i  (e0[gi]),
        .q1_i  (e1[gi]),
        .p2_i  (tv[(gj == 1) ? 1 : 0]),
        .q2_i  (tv[(gj == 0) ? 1 : 2]),
        .hit_o (seg_hit[gi*3+gj])
      );
    end
  end

  assign overlap_o = (|vtx_in) || (|cor_in) || (|seg_hit);

endmodule

@@ rtl/rectangle_triangle_overlap.sv @@
// Top level of the rectangle/triangle overlap block: input register, evaluation
// logic and result register with valid/ready flow control. Depends on rto_pkg, rto_eval.
//
// Usage: a query (rectangle corner, width, height and three triangle vertices)
// is presented on the input channel with in_valid_i; it transfers on a rising
// edge where in_valid_i and in_ready_o are both high. Each query yields exactly
// one result on the output channel, overlap_o, which transfers when out_valid_o
// and out_ready_i are both high. A result is 1 when the shapes overlap or touch.
// The query is held in the input register and its result loads into the result
// register when the output channel can advance. Throughput is one query per
// cycle while the receiver does not stall; the evaluation of a query is a single
// pass of exact determinant logic between those two registers, so back-to-back
// queries are taken every cycle while out_ready_i is high.
// When the receiver stalls, the result register holds its value and a second
// query can still be captured in the input register; only then does in_ready_o
// drop. Reset empties both registers; no results are pending after reset.
module rectangle_triangle_overlap import rto_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] rect_x_i,
  input  logic signed [COORD_BITS-1:0] rect_y_i,
  input  logic [SIZE_BITS-1:0]         rect_w_i,
  input  logic [SIZE_BITS-1:0]         rect_h_i,
  input  logic signed [COORD_BITS-1:0] tri_ax_i,
  input  logic signed [COORD_BITS-1:0] tri_ay_i,
  input  logic signed [COORD_BITS-1:0] tri_bx_i,
  input  logic signed [COORD_BITS-1:0] tri_by_i,
  input  logic signed [COORD_BITS-1:0] tri_cx_i,
  input  logic signed [COORD_BITS-1:0] tri_cy_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         overlap_o
);

  query_t query_d, query_q;
  logic   s1_valid_q;
  logic   out_valid_q;
  logic   overlap_d, overlap_q;
  logic   out_en;
  logic   in_xfer;

  assign out_en     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_en;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign query_d = '{rect_x: rect_x_i, rect_y: rect_y_i, rect_w: rect_w_i,
                     rect_h: rect_h_i, tri_ax: tri_ax_i, tri_ay: tri_ay_i,
                     tri_bx: tri_bx_i, tri_by: tri_by_i, tri_cx: tri_cx_i,
                     tri_cy: tri_cy_i};

  rto_eval u_eval (
    .query_i   (query_q),
    .overlap_o (overlap_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      query_q <= query_d;
    end
    if (out_en && s1_valid_q) begin
      overlap_q <= overlap_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign overlap_o   = overlap_q;

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input not ready while the input register is empty");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_en |=> out_valid_o)
    else $error("query in the input register did not reach the result register");

  a_hold_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_en |=> s1_valid_q && $stable(query_q))
    else $error("stalled query was lost or changed");
`endif

endmodule
